[sv/deh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event heap package
// Shared widths, entry type and operation and result codes.
// ----------------------------------------------------------------------------
package deh_pkg;

    localparam int Depth    = 64;
    localparam int IdxW     = $clog2(Depth);
    localparam int CntW     = $clog2(Depth + 1);
    localparam int MaxFired = 64;
    localparam int FireW    = $clog2(MaxFired + 1);
    localparam int EntryW   = 32 + 8 + 32 + 32;

    typedef enum logic [1:0] {
        FUNC_ADD        = 2'd0,
        FUNC_CANCEL_EX  = 2'd1,
        FUNC_CANCEL_WC  = 2'd2,
        FUNC_TICK       = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_CANCEL  = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  handler;
        logic [31:0] first;
        logic [31:0] second;
    } entry_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] delay;
        logic [7:0]  handler_id;
        logic [31:0] tag_first;
        logic [31:0] tag_second;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  fired_handler;
        logic [31:0] fired_first;
        logic [31:0] fired_second;
        logic [6:0]  cancel_count;
        logic        last;
    } rsp_t;

endpackage

[sv/deh_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event heap channel interfaces
// Valid/ready channels carrying a request or a result.
// ----------------------------------------------------------------------------
interface deh_req_if;
    logic            valid;
    logic            ready;
    deh_pkg::req_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface deh_rsp_if;
    logic            valid;
    logic            ready;
    deh_pkg::rsp_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/deh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module deh_ram #(
    parameter int Width = 8,
    parameter int Size  = 64
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [$clog2(Size)-1:0] addr,
    input  logic [Width-1:0]        wdata,
    output logic [Width-1:0]        rdata
);
    logic [Width-1:0] mem [Size];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[sv/deadline_event_heap_core.sv]
`timescale 1ns / 1ps
// Steps: add walks up the heap one level at a time, reading the parent and writing the hole,
// then registers its result. Cancel reads and checks every stored entry. A tick pops each
// due event, sifts the last entry down level by level, fires each live event and then finishes.
// Throughput: one request at a time; ready stays low until its last result is registered,
// and every result waits for the output register to be free. Reset clears the entry
// count, the time and the sequencer; heap contents need no clearing.
// ----------------------------------------------------------------------------
// Deadline event heap core
// Timer queue held as a binary min-heap in one single-port RAM, walked by a
// small sequencer. Results leave through a one-entry output register.
// ----------------------------------------------------------------------------
module deadline_event_heap_core (
    input  logic           clk,
    input  logic           rst_n,
    deh_req_if.sink        req,
    deh_rsp_if.source      rsp
);
    import deh_pkg::*;

    // Heap positions are one-based, stored at position minus one.
    typedef enum logic [3:0] {
        S_IDLE, S_ADD_RD, S_ADD_CMP, S_CAN_RD, S_CAN_CHK,
        S_TICK_RD, S_TICK_CHK, S_POP_LAST, S_POP_LW,
        S_DN_RDL, S_DN_RDR, S_DN_CMP, S_FIRE, S_EMIT, S_DONE
    } state_t;

    state_t           state_reg;
    req_t             cur_reg;
    logic [CntW-1:0]  count_reg;
    logic [31:0]      time_reg;
    logic [CntW:0]    pos_reg;     // current hole, one-based
    logic [CntW:0]    kid_reg;     // child being examined
    entry_t           hold_reg;    // entry being sifted
    entry_t           left_reg;
    logic [6:0]       ccnt_reg;
    logic [FireW-1:0] fired_reg;
    entry_t           top_reg;
    logic             top_live_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;
    rsp_t             pend_reg;    // result waiting for the output register

    logic             ram_we;
    logic [IdxW-1:0]  ram_addr;
    entry_t           ram_wdata;
    logic [EntryW-1:0] ram_rdata;
    entry_t           rd;

    assign rd = entry_t'(ram_rdata);

    deh_ram #(.Width(EntryW), .Size(Depth)) u_heap (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    function automatic logic [IdxW-1:0] slot(input logic [CntW:0] p);
        logic [CntW:0] q;
        q = p - 1'b1;
        return q[IdxW-1:0];
    endfunction

    function automatic rsp_t mk_rsp(input kind_t k, input logic [7:0] h,
                                    input logic [31:0] a, input logic [31:0] b,
                                    input logic [6:0] c, input logic l);
        rsp_t r;
        r.kind          = k;
        r.fired_handler = h;
        r.fired_first   = a;
        r.fired_second  = b;
        r.cancel_count  = c;
        r.last          = l;
        return r;
    endfunction

    // Cancel match against the entry read back.
    logic cancel_hit;
    always_comb
    begin
        if (cur_reg.func == FUNC_CANCEL_EX)
        begin
            cancel_hit = rd.first == cur_reg.tag_first && rd.second == cur_reg.tag_second;
        end
        else
        begin
            cancel_hit = (cur_reg.tag_first == '0 || rd.first == cur_reg.tag_first) &&
                         (cur_reg.tag_second == '0 || rd.second == cur_reg.tag_second);
        end
        cancel_hit = cancel_hit && rd.handler == cur_reg.handler_id &&
                     cur_reg.handler_id != '0;
    end

    logic [CntW:0] par;
    assign par = pos_reg >> 1;

    // Sift-up moves past a parent only when that parent is strictly later.
    logic add_up;
    assign add_up = par != '0 && hold_reg.deadline < rd.deadline;

    // Sift-down: the right child wins only when the left one is strictly later,
    // and the sinking entry moves only when it is strictly later than that child.
    logic          dn_right;
    entry_t        dn_child;
    logic [CntW:0] dn_kid;
    logic          dn_move;
    assign dn_right = kid_reg < {1'b0, count_reg} && left_reg.deadline > rd.deadline;
    assign dn_child = dn_right ? rd : left_reg;
    assign dn_kid   = dn_right ? kid_reg + 1'b1 : kid_reg;
    assign dn_move  = kid_reg <= {1'b0, count_reg} && hold_reg.deadline > dn_child.deadline;

    // RAM port control, combinational from state.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = slot(pos_reg);
        ram_wdata = hold_reg;
        unique case (state_reg)
            S_ADD_RD:   ram_addr = slot(par);
            S_ADD_CMP:
            begin
                ram_we = 1'b1;
                if (add_up)
                begin
                    ram_wdata = rd;
                end
            end
            S_CAN_CHK:
            begin
                ram_addr = slot(pos_reg);
                if (cancel_hit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rd;
                    ram_wdata.handler = '0;
                end
            end
            S_TICK_RD:  ram_addr = '0;
            S_POP_LAST: ram_addr = slot({1'b0, count_reg});
            S_DN_RDL:   ram_addr = slot(kid_reg);
            S_DN_RDR:   ram_addr = slot(kid_reg + 1'b1);
            S_DN_CMP:
            begin
                ram_we   = 1'b1;
                ram_addr = slot(pos_reg);
                if (dn_move)
                begin
                    ram_wdata = dn_child;
                end
            end
            default: ;
        endcase
    end

    assign req.ready = state_reg == S_IDLE;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // A fired event is held back until the next pop shows whether it is the
    // final one; the held event then leaves and the new one takes its place.
    rsp_t fire_rsp;
    rsp_t done_rsp;
    logic out_free;
    logic out_load;
    always_comb
    begin
        fire_rsp = mk_rsp(KIND_FIRED, top_reg.handler, top_reg.first, top_reg.second,
                          7'd0, 1'b0);
        done_rsp = pend_reg;
        done_rsp.last = 1'b1;
        if (fired_reg == '0)
        begin
            done_rsp = mk_rsp(KIND_NONE, 8'd0, 32'd0, 32'd0, 7'd0, 1'b1);
        end
        out_free = !out_valid_reg || rsp.ready;
        out_load = out_free && (state_reg == S_EMIT || state_reg == S_DONE ||
                                (state_reg == S_FIRE && fired_reg != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            count_reg     <= '0;
            time_reg      <= '0;
            pos_reg       <= '0;
            kid_reg       <= '0;
            hold_reg      <= '0;
            left_reg      <= '0;
            ccnt_reg      <= '0;
            fired_reg     <= '0;
            top_reg       <= '0;
            top_live_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !rsp.ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cur_reg   <= req.data;
                        ccnt_reg  <= '0;
                        fired_reg <= '0;
                        unique case (func_t'(req.data.func)) inside
                            FUNC_ADD:
                            begin
                                hold_reg <= '{deadline: time_reg + {8'd0, req.data.delay},
                                              handler:  req.data.handler_id,
                                              first:    req.data.tag_first,
                                              second:   req.data.tag_second};
                                if (count_reg >= CntW'(Depth))
                                begin
                                    pend_reg  <= mk_rsp(KIND_FULL, 8'd0, 32'd0, 32'd0,
                                                        7'd0, 1'b1);
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    pos_reg   <= {1'b0, count_reg} + 1'b1;
                                    state_reg <= S_ADD_RD;
                                end
                            end
                            FUNC_CANCEL_EX, FUNC_CANCEL_WC:
                            begin
                                pos_reg   <= (CntW+1)'(1);
                                state_reg <= S_CAN_RD;
                            end
                            default:
                            begin
                                time_reg  <= time_reg + 1'b1;
                                state_reg <= S_TICK_RD;
                            end
                        endcase
                    end
                end
                S_ADD_RD:  state_reg <= S_ADD_CMP;
                S_ADD_CMP:
                begin
                    if (add_up)
                    begin
                        pos_reg   <= par;
                        state_reg <= S_ADD_RD;
                    end
                    else
                    begin
                        pend_reg  <= mk_rsp(KIND_ADDED, 8'd0, 32'd0, 32'd0, 7'd0, 1'b1);
                        state_reg <= S_EMIT;
                    end
                end
                S_CAN_RD:
                begin
                    if (pos_reg > {1'b0, count_reg})
                    begin
                        pend_reg  <= mk_rsp(KIND_CANCEL, 8'd0, 32'd0, 32'd0, ccnt_reg, 1'b1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_CAN_CHK;
                    end
                end
                S_CAN_CHK:
                begin
                    if (cancel_hit && ccnt_reg != 7'd127)
                    begin
                        ccnt_reg <= ccnt_reg + 1'b1;
                    end
                    pos_reg   <= pos_reg + 1'b1;
                    state_reg <= S_CAN_RD;
                end
                S_TICK_RD:
                begin
                    if (count_reg == '0 || fired_reg == FireW'(MaxFired))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_TICK_CHK;
                    end
                end
                S_TICK_CHK:
                begin
                    if (rd.deadline <= time_reg)
                    begin
                        top_reg      <= rd;
                        top_live_reg <= rd.handler != '0;
                        state_reg    <= S_POP_LAST;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_POP_LAST:
                begin
                    count_reg <= count_reg - 1'b1;
                    pos_reg   <= (CntW+1)'(1);
                    kid_reg   <= (CntW+1)'(2);
                    state_reg <= S_POP_LW;
                end
                S_POP_LW:
                begin
                    hold_reg  <= rd;
                    state_reg <= S_DN_RDL;
                end
                S_DN_RDL:
                begin
                    if (kid_reg > {1'b0, count_reg})
                    begin
                        state_reg <= S_DN_CMP;
                    end
                    else
                    begin
                        state_reg <= S_DN_RDR;
                    end
                end
                S_DN_RDR:
                begin
                    left_reg  <= rd;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (dn_move)
                    begin
                        pos_reg   <= dn_kid;
                        kid_reg   <= {dn_kid[CntW-1:0], 1'b0};
                        state_reg <= S_DN_RDL;
                    end
                    else if (top_live_reg)
                    begin
                        state_reg <= S_FIRE;
                    end
                    else
                    begin
                        state_reg <= S_TICK_RD;
                    end
                end
                S_FIRE:
                begin
                    if (fired_reg == '0)
                    begin
                        pend_reg  <= fire_rsp;
                        fired_reg <= fired_reg + 1'b1;
                        state_reg <= S_TICK_RD;
                    end
                    else if (out_free)
                    begin
                        out_reg   <= pend_reg;
                        pend_reg  <= fire_rsp;
                        fired_reg <= fired_reg + 1'b1;
                        state_reg <= S_TICK_RD;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= pend_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg   <= done_rsp;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("entry count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped while stalled");
    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fired_reg <= FireW'(MaxFired))
        else $error("fired count above cap");
endmodule
